// ===== rtl/core/tbss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbss_pkg: shared types and constants for the two-body spring stepper
// Word widths, sequencer states, configuration indexes and the request and
// response bundles of the shared divider and square-root units.
// ----------------------------------------------------------------------------
package tbss_pkg;

    // Data widths: 32-bit signed state words, 64-bit products
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // Saturation bounds of a signed word, held at product width
    localparam logic signed [PROD_W-1:0] SAT_HI = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
    localparam logic signed [PROD_W-1:0] SAT_LO = -(64'sd1 <<< (WORD_W - 1));

    // Register reset values
    localparam logic [CFG_W-1:0] REST_LENGTH_RST = 31'd6553600;
    localparam logic [CFG_W-1:0] SPRING_K_RST    = 31'd3277;
    localparam logic [CFG_W-1:0] MASS_FIRST_RST  = 31'd6553600;
    localparam logic [CFG_W-1:0] MASS_SECOND_RST = 31'd6553600;
    localparam logic [CFG_W-1:0] TIME_STEP_RST   = 31'd1049;

    // Item operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_LENGTH = 3'd0,
        CFG_SPRING_K    = 3'd1,
        CFG_MASS_FIRST  = 3'd2,
        CFG_MASS_SECOND = 3'd3,
        CFG_TIME_STEP   = 3'd4
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_STRETCH,
        ST_Q_MUL,
        ST_Q_DIV,
        ST_Q_DIV_WAIT,
        ST_F_MUL,
        ST_F_CAP,
        ST_ACC_DIV,
        ST_ACC_WAIT,
        ST_V_ADD,
        ST_P_MUL,
        ST_P_CAP,
        ST_P_ADD,
        ST_DONE
    } seq_state_t;

    // Divider handshake
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

    // Square-root handshake
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] radicand;
    } root_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] root;
    } root_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tbss_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbss_mul: shared registered multiplier
// Signed 32 x 32 multiply; the full 64-bit product is registered and is
// valid in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module tbss_mul (
    input  wire logic                                  clk,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]   a,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]   b,
    output logic signed [tbss_pkg::PROD_W-1:0]        p
);

    logic signed [tbss_pkg::PROD_W-1:0] p_next;
    logic signed [tbss_pkg::PROD_W-1:0] p_reg;

    // full-width signed product
    assign p_next = a * b;

    // product register
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/core/tbss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbss_div: shared iterative divider
// Restoring unsigned division of a 64-bit dividend by a 32-bit nonzero
// divisor, one quotient bit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module tbss_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tbss_pkg::div_req_t req,
    output tbss_pkg::div_rsp_t      rsp
);

    localparam int WW = tbss_pkg::WORD_W;
    localparam int PW = tbss_pkg::PROD_W;
    localparam int CW = $clog2(PW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [WW-1:0] rem_reg, rem_next;
    logic [WW-1:0] dvs_reg, dvs_next;

    logic [WW:0]   rem_shift;
    logic [WW:0]   rem_diff;
    logic          fits;

    // one trial subtraction per cycle
    assign rem_shift = {rem_reg, quo_reg[PW-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(PW - 1);
            quo_next   = req.dividend;
            rem_next   = '0;
            dvs_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[PW-2:0], fits};
            rem_next   = fits ? rem_diff[WW-1:0] : rem_shift[WW-1:0];
            count_next = count_reg - CW'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/tbss_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tbss_sqrt: iterative integer square root
// Digit-by-digit floor square root of a 64-bit radicand, one root bit per
// cycle; done pulses with the root.
// ----------------------------------------------------------------------------
module tbss_sqrt (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tbss_pkg::root_req_t req,
    output tbss_pkg::root_rsp_t      rsp
);

    localparam int RW = tbss_pkg::WORD_W;
    localparam int PW = tbss_pkg::PROD_W;
    localparam int CW = $clog2(RW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] rad_reg, rad_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW+1:0] rem_reg, rem_next;

    logic [RW+1:0] rem_shift;
    logic [RW+1:0] trial;
    logic [RW+1:0] rem_diff;
    logic          fits;

    // bring down two radicand bits, try root*4+1
    assign rem_shift = {rem_reg[RW-1:0], rad_reg[PW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign rem_diff  = rem_shift - trial;
    assign fits      = (rem_shift >= trial);

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(RW - 1);
            rad_next   = req.radicand;
            root_next  = '0;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rad_next   = {rad_reg[PW-3:0], 2'b00};
            root_next  = {root_reg[RW-2:0], fits};
            rem_next   = fits ? rem_diff : rem_shift;
            count_next = count_reg - CW'(1);
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule
`default_nettype wire

// ===== rtl/core/two_body_spring_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_body_spring_step: two bodies on a spring, semi-implicit Euler stepper
// Holds position and velocity of two bodies in signed fixed point and
// advances them under the spring force, with saturating arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation selects a tick (advance both
//   bodies one step) or a load (write position and velocity of body_select).
//   Output channel (out_valid/out_ready): one transfer per item carrying both
//   positions after the item.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 rest
//   length, 1 stiffness, 2 and 3 masses, 4 time step); write only when idle.
//   Sequence: a load goes from the idle state to the done state and on to the
//   output register. A tick runs the shared 64-step divider six times (two
//   force quotients, four accelerations; only the four when the bodies
//   coincide), plus a 32-step square root and its multiplies on one shared
//   multiplier. One item is in work at a time; in_ready is high only idle.
//   Reset: bodies at rest at the origin, registers at their defaults; no
//   clearing pass is needed.
//   Stall: results sit in an output register; the next item can be taken
//   while a result waits, and the sequencer holds at its end until the
//   output register is free.
// ----------------------------------------------------------------------------
module two_body_spring_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [tbss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [tbss_pkg::CFG_W-1:0]             cfg_data,
    // input channel
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   operation,
    input  wire logic                                   body_select,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]     load_pos_x,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]     load_pos_y,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]     load_vel_x,
    input  wire logic signed [tbss_pkg::WORD_W-1:0]     load_vel_y,
    // output channel
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [tbss_pkg::WORD_W-1:0]          first_x,
    output logic signed [tbss_pkg::WORD_W-1:0]          first_y,
    output logic signed [tbss_pkg::WORD_W-1:0]          second_x,
    output logic signed [tbss_pkg::WORD_W-1:0]          second_y
);

    localparam int WW = tbss_pkg::WORD_W;
    localparam int PW = tbss_pkg::PROD_W;
    localparam int CFW = tbss_pkg::CFG_W;

    // bias that turns an arithmetic shift into truncation toward zero
    localparam logic signed [PW-1:0] ROUND_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // saturate a wide signed value to a word
    function automatic logic signed [WW-1:0] sat_word(input logic signed [PW-1:0] v);
        logic signed [WW-1:0] r;
        if (v > tbss_pkg::SAT_HI)
            r = WW'(tbss_pkg::SAT_HI);
        else if (v < tbss_pkg::SAT_LO)
            r = WW'(tbss_pkg::SAT_LO);
        else
            r = WW'(v);
        return r;
    endfunction

    // product scaled down by the fraction bits, truncated toward zero
    function automatic logic signed [WW-1:0] fx_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] biased;
        logic signed [PW-1:0] shifted;
        biased  = p[PW-1] ? (p + ROUND_BIAS) : p;
        shifted = biased >>> FRAC_BITS;
        return sat_word(shifted);
    endfunction

    // saturating negate
    function automatic logic signed [WW-1:0] neg_sat(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        if (v == WW'(tbss_pkg::SAT_LO))
            r = WW'(tbss_pkg::SAT_HI);
        else
            r = -v;
        return r;
    endfunction

    // configuration registers
    logic [CFW-1:0] rest_length_reg;
    logic [CFW-1:0] spring_k_reg;
    logic [CFW-1:0] mass_first_reg;
    logic [CFW-1:0] mass_second_reg;
    logic [CFW-1:0] time_step_reg;

    // sequencer
    tbss_pkg::seq_state_t state_reg, state_next;
    logic body_reg, body_next;
    logic axis_reg, axis_next;

    // body state, indexed [body][axis], axis 0 is x
    logic signed [WW-1:0] pos_reg [2][2];
    logic signed [WW-1:0] pos_next [2][2];
    logic signed [WW-1:0] vel_reg [2][2];
    logic signed [WW-1:0] vel_next [2][2];

    // working values
    logic signed [WW-1:0] dx_reg, dx_next;
    logic signed [WW-1:0] dy_reg, dy_next;
    logic [PW-1:0]        sq_reg, sq_next;
    logic [WW-1:0]        len_reg, len_next;
    logic signed [WW-1:0] stretch_reg, stretch_next;
    logic signed [WW-1:0] tmp_reg, tmp_next;
    logic                 neg_reg, neg_next;
    logic signed [WW-1:0] force_reg [2];
    logic signed [WW-1:0] force_next [2];

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [WW-1:0] first_x_reg, first_x_next;
    logic signed [WW-1:0] first_y_reg, first_y_next;
    logic signed [WW-1:0] second_x_reg, second_x_next;
    logic signed [WW-1:0] second_y_reg, second_y_next;

    // shared units
    logic signed [WW-1:0] mul_a;
    logic signed [WW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    tbss_pkg::div_req_t   div_req;
    tbss_pkg::div_rsp_t   div_rsp;
    tbss_pkg::root_req_t  root_req;
    tbss_pkg::root_rsp_t  root_rsp;

    // operand helpers
    logic [PW-1:0]        prod_mag;
    logic signed [WW-1:0] force_cur;
    logic signed [WW-1:0] force_sel;
    logic signed [PW-1:0] force_ext;
    logic [PW-1:0]        force_mag;
    logic [CFW-1:0]       mass_cur;
    logic [WW-1:0]        mass_div;
    logic signed [WW-1:0] vel_cur;
    logic signed [WW-1:0] pos_cur;
    logic signed [PW-1:0] quot_s;

    tbss_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tbss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tbss_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_length_reg <= tbss_pkg::REST_LENGTH_RST;
            spring_k_reg    <= tbss_pkg::SPRING_K_RST;
            mass_first_reg  <= tbss_pkg::MASS_FIRST_RST;
            mass_second_reg <= tbss_pkg::MASS_SECOND_RST;
            time_step_reg   <= tbss_pkg::TIME_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tbss_pkg::CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                tbss_pkg::CFG_SPRING_K:    spring_k_reg    <= cfg_data;
                tbss_pkg::CFG_MASS_FIRST:  mass_first_reg  <= cfg_data;
                tbss_pkg::CFG_MASS_SECOND: mass_second_reg <= cfg_data;
                tbss_pkg::CFG_TIME_STEP:   time_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection shared by several states
    always_comb
    begin
        prod_mag  = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);
        force_cur = force_reg[axis_reg];
        force_sel = body_reg ? neg_sat(force_cur) : force_cur;
        force_ext = PW'(force_sel);
        force_mag = force_ext[PW-1] ? PW'(-force_ext) : PW'(force_ext);
        mass_cur  = body_reg ? mass_second_reg : mass_first_reg;
        // a zero mass counts as one LSB
        mass_div  = (mass_cur == '0) ? WW'(1) : WW'(mass_cur);
        vel_cur   = vel_reg[body_reg][axis_reg];
        pos_cur   = pos_reg[body_reg][axis_reg];
        quot_s    = $signed(div_rsp.quotient);
    end

    // sequencer: next state, datapath updates and unit requests
    always_comb
    begin
        state_next     = state_reg;
        body_next      = body_reg;
        axis_next      = axis_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq_next        = sq_reg;
        len_next       = len_reg;
        stretch_next   = stretch_reg;
        tmp_next       = tmp_reg;
        neg_next       = neg_reg;
        force_next     = force_reg;
        out_valid_next = out_valid_reg && !out_ready;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        second_x_next  = second_x_reg;
        second_y_next  = second_y_reg;
        mul_a          = dx_reg;
        mul_b          = dx_reg;
        div_req        = '0;
        root_req       = '0;

        case (state_reg)
            tbss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == tbss_pkg::OP_LOAD)
                    begin
                        pos_next[body_select][0] = load_pos_x;
                        pos_next[body_select][1] = load_pos_y;
                        vel_next[body_select][0] = load_vel_x;
                        vel_next[body_select][1] = load_vel_y;
                        state_next = tbss_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tbss_pkg::ST_DIFF;
                    end
                end
            end

            // separation vector
            tbss_pkg::ST_DIFF:
            begin
                dx_next    = sat_word(PW'(pos_reg[1][0]) - PW'(pos_reg[0][0]));
                dy_next    = sat_word(PW'(pos_reg[1][1]) - PW'(pos_reg[0][1]));
                state_next = tbss_pkg::ST_SQ_X;
            end

            tbss_pkg::ST_SQ_X:
            begin
                mul_a      = dx_reg;
                mul_b      = dx_reg;
                state_next = tbss_pkg::ST_SQ_Y;
            end

            tbss_pkg::ST_SQ_Y:
            begin
                mul_a      = dy_reg;
                mul_b      = dy_reg;
                sq_next    = $unsigned(mul_p);
                state_next = tbss_pkg::ST_SQ_SUM;
            end

            tbss_pkg::ST_SQ_SUM:
            begin
                sq_next    = sq_reg + $unsigned(mul_p);
                state_next = tbss_pkg::ST_ROOT;
            end

            // spring length
            tbss_pkg::ST_ROOT:
            begin
                root_req.start    = 1'b1;
                root_req.radicand = sq_reg;
                state_next        = tbss_pkg::ST_ROOT_WAIT;
            end

            tbss_pkg::ST_ROOT_WAIT:
            begin
                if (root_rsp.done)
                begin
                    len_next  = root_rsp.root;
                    axis_next = 1'b0;
                    body_next = 1'b0;
                    if (root_rsp.root == '0)
                    begin
                        // coincident bodies: no force
                        force_next[0] = '0;
                        force_next[1] = '0;
                        state_next    = tbss_pkg::ST_ACC_DIV;
                    end
                    else
                    begin
                        state_next = tbss_pkg::ST_STRETCH;
                    end
                end
            end

            tbss_pkg::ST_STRETCH:
            begin
                stretch_next = sat_word($signed(PW'(len_reg)) - $signed(PW'(rest_length_reg)));
                state_next   = tbss_pkg::ST_Q_MUL;
            end

            // d * stretch / L per axis
            tbss_pkg::ST_Q_MUL:
            begin
                mul_a      = axis_reg ? dy_reg : dx_reg;
                mul_b      = stretch_reg;
                state_next = tbss_pkg::ST_Q_DIV;
            end

            tbss_pkg::ST_Q_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_mag;
                div_req.divisor  = len_reg;
                neg_next         = mul_p[PW-1];
                state_next       = tbss_pkg::ST_Q_DIV_WAIT;
            end

            tbss_pkg::ST_Q_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // |q| stays below 2^31, so a word holds it
                    tmp_next = neg_reg ? (WW'(0) - WW'(div_rsp.quotient))
                                       : WW'(div_rsp.quotient);
                    state_next = tbss_pkg::ST_F_MUL;
                end
            end

            tbss_pkg::ST_F_MUL:
            begin
                mul_a      = tmp_reg;
                mul_b      = $signed({1'b0, spring_k_reg});
                state_next = tbss_pkg::ST_F_CAP;
            end

            tbss_pkg::ST_F_CAP:
            begin
                force_next[axis_reg] = fx_scale(mul_p);
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = tbss_pkg::ST_Q_MUL;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = tbss_pkg::ST_ACC_DIV;
                end
            end

            // acceleration = force << frac / mass
            tbss_pkg::ST_ACC_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = force_mag << FRAC_BITS;
                div_req.divisor  = mass_div;
                neg_next         = force_sel[WW-1];
                state_next       = tbss_pkg::ST_ACC_WAIT;
            end

            tbss_pkg::ST_ACC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    tmp_next   = neg_reg ? sat_word(-quot_s) : sat_word(quot_s);
                    state_next = tbss_pkg::ST_V_ADD;
                end
            end

            tbss_pkg::ST_V_ADD:
            begin
                vel_next[body_reg][axis_reg] = sat_word(PW'(vel_cur) + PW'(tmp_reg));
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = tbss_pkg::ST_ACC_DIV;
                end
                else
                begin
                    axis_next  = 1'b0;
                    state_next = tbss_pkg::ST_P_MUL;
                end
            end

            // position += v * dt
            tbss_pkg::ST_P_MUL:
            begin
                mul_a      = vel_cur;
                mul_b      = $signed({1'b0, time_step_reg});
                state_next = tbss_pkg::ST_P_CAP;
            end

            tbss_pkg::ST_P_CAP:
            begin
                tmp_next   = fx_scale(mul_p);
                state_next = tbss_pkg::ST_P_ADD;
            end

            tbss_pkg::ST_P_ADD:
            begin
                pos_next[body_reg][axis_reg] = sat_word(PW'(pos_cur) + PW'(tmp_reg));
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = tbss_pkg::ST_P_MUL;
                end
                else
                begin
                    axis_next = 1'b0;
                    if (!body_reg)
                    begin
                        body_next  = 1'b1;
                        state_next = tbss_pkg::ST_ACC_DIV;
                    end
                    else
                    begin
                        state_next = tbss_pkg::ST_DONE;
                    end
                end
            end

            // hand positions to the output register once it is free
            tbss_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    first_x_next   = pos_reg[0][0];
                    first_y_next   = pos_reg[0][1];
                    second_x_next  = pos_reg[1][0];
                    second_y_next  = pos_reg[1][1];
                    out_valid_next = 1'b1;
                    state_next     = tbss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tbss_pkg::ST_IDLE;
            end
        endcase
    end

    // control and body state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbss_pkg::ST_IDLE;
            body_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '{default: '0};
            vel_reg       <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            body_reg      <= body_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
        end
    end

    // working values and output payload
    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sq_reg       <= sq_next;
        len_reg      <= len_next;
        stretch_reg  <= stretch_next;
        tmp_reg      <= tmp_next;
        neg_reg      <= neg_next;
        force_reg    <= force_next;
        first_x_reg  <= first_x_next;
        first_y_reg  <= first_y_next;
        second_x_reg <= second_x_next;
        second_y_reg <= second_y_next;
    end

    assign in_ready  = (state_reg == tbss_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign first_x   = first_x_reg;
    assign first_y   = first_y_reg;
    assign second_x  = second_x_reg;
    assign second_y  = second_y_reg;

    // divider results only arrive while the sequencer waits for them
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == tbss_pkg::ST_Q_DIV_WAIT ||
                          state_reg == tbss_pkg::ST_ACC_WAIT))
        else $error("divider finished outside a wait state");

    // root result only arrives while the sequencer waits for it
    a_root_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        root_rsp.done |-> (state_reg == tbss_pkg::ST_ROOT_WAIT))
        else $error("square root finished outside its wait state");

    // a load goes straight to result delivery
    a_load_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == tbss_pkg::OP_LOAD))
        |=> (state_reg == tbss_pkg::ST_DONE))
        else $error("load transfer did not go to result delivery");

    // a new result is only raised from the delivery state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == tbss_pkg::ST_DONE))
        else $error("result raised outside the delivery state");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for two_body_spring_step
// Feeds load and tick items through the input channel with random gaps on
// both sides. A local saturating fixed-point copy of the two bodies is
// stepped on every input transfer, and each output transfer is checked field
// by field against it. Register settings change between phases, and only
// once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     FRAC         = 16;
    localparam int     HALF_PER     = 6;
    localparam int     RESET_CYCLES = 8;
    localparam longint CYCLE_LIMIT  = 2000000;
    localparam int     DRAIN_CYCLES = 600;
    localparam int     PHASE_ITEMS  = 85;

    // register indexes that map to nothing
    localparam logic [tbss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [tbss_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef logic signed [tbss_pkg::WORD_W-1:0] word_t;

    localparam word_t W_MAX = tbss_pkg::SAT_HI[tbss_pkg::WORD_W-1:0];
    localparam word_t W_MIN = tbss_pkg::SAT_LO[tbss_pkg::WORD_W-1:0];

    typedef struct {
        logic  op;
        logic  sel;
        word_t px;
        word_t py;
        word_t vx;
        word_t vy;
    } body_item_t;

    typedef struct {
        word_t fx;
        word_t fy;
        word_t sx;
        word_t sy;
    } body_pos_t;

    // DUT ports
    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [tbss_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [tbss_pkg::CFG_W-1:0]     cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic                           operation   = tbss_pkg::OP_TICK;
    logic                           body_select = 1'b0;
    word_t                          load_pos_x  = '0;
    word_t                          load_pos_y  = '0;
    word_t                          load_vel_x  = '0;
    word_t                          load_vel_y  = '0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    word_t                          first_x;
    word_t                          first_y;
    word_t                          second_x;
    word_t                          second_y;

    // stimulus and checking state
    body_item_t pending_items[$];
    body_pos_t  expected_pos[$];
    body_item_t cur_item;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         calm     = 1'b0;
    bit         in_took  = 1'b0;
    bit         out_took = 1'b0;
    int         errors   = 0;
    longint     cycles   = 0;

    // local copy of the bodies and registers
    longint pos_x[2] = '{0, 0};
    longint pos_y[2] = '{0, 0};
    longint vel_x[2] = '{0, 0};
    longint vel_y[2] = '{0, 0};
    longint rest_len = tbss_pkg::REST_LENGTH_RST;
    longint stiff    = tbss_pkg::SPRING_K_RST;
    longint mass_a   = tbss_pkg::MASS_FIRST_RST;
    longint mass_b   = tbss_pkg::MASS_SECOND_RST;
    longint dt       = tbss_pkg::TIME_STEP_RST;

    two_body_spring_step #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .body_select (body_select),
        .load_pos_x  (load_pos_x),
        .load_pos_y  (load_pos_y),
        .load_vel_x  (load_vel_x),
        .load_vel_y  (load_vel_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .first_x     (first_x),
        .first_y     (first_y),
        .second_x    (second_x),
        .second_y    (second_y)
    );

    initial
    begin
        forever #HALF_PER clk = ~clk;
    end

    // ------------------------------------------------------------------
    // fixed-point arithmetic of the stepper
    // ------------------------------------------------------------------
    function automatic longint clamp_word(longint v);
        if (v > longint'(tbss_pkg::SAT_HI))
            return longint'(tbss_pkg::SAT_HI);
        if (v < longint'(tbss_pkg::SAT_LO))
            return longint'(tbss_pkg::SAT_LO);
        return v;
    endfunction

    // product with the fraction dropped, truncated toward zero
    function automatic longint scale_mul(longint a, longint b);
        return clamp_word((a * b) / (longint'(1) <<< FRAC));
    endfunction

    // force over mass; a zero mass counts as one LSB
    function automatic longint accel(longint f, longint m);
        longint d;
        d = (m <= 0) ? 1 : m;
        return clamp_word((f * (longint'(1) <<< FRAC)) / d);
    endfunction

    // bitwise floor square root
    function automatic longint floor_root(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= n)
                r = t;
        end
        return longint'(r);
    endfunction

    function automatic void push_body(int b, longint f_x, longint f_y, longint m);
        vel_x[b] = clamp_word(vel_x[b] + accel(f_x, m));
        vel_y[b] = clamp_word(vel_y[b] + accel(f_y, m));
        pos_x[b] = clamp_word(pos_x[b] + scale_mul(vel_x[b], dt));
        pos_y[b] = clamp_word(pos_y[b] + scale_mul(vel_y[b], dt));
    endfunction

    // one Euler step; force taken from positions before the step
    function automatic void spring_tick();
        longint    dx;
        longint    dy;
        longint    len;
        longint    stretch;
        longint    f_x;
        longint    f_y;
        bit [63:0] sq;
        dx  = clamp_word(pos_x[1] - pos_x[0]);
        dy  = clamp_word(pos_y[1] - pos_y[0]);
        sq  = dx * dx;
        sq  = sq + 64'(dy * dy);
        len = floor_root(sq);
        f_x = 0;
        f_y = 0;
        if (len != 0)
        begin
            stretch = clamp_word(len - rest_len);
            f_x     = scale_mul((dx * stretch) / len, stiff);
            f_y     = scale_mul((dy * stretch) / len, stiff);
        end
        push_body(0, f_x, f_y, mass_a);
        push_body(1, clamp_word(-f_x), clamp_word(-f_y), mass_b);
    endfunction

    function automatic body_pos_t step_bodies(body_item_t it);
        body_pos_t r;
        if (it.op == tbss_pkg::OP_LOAD)
        begin
            pos_x[it.sel] = longint'(it.px);
            pos_y[it.sel] = longint'(it.py);
            vel_x[it.sel] = longint'(it.vx);
            vel_y[it.sel] = longint'(it.vy);
        end
        else
        begin
            spring_tick();
        end
        r.fx = word_t'(pos_x[0]);
        r.fy = word_t'(pos_y[0]);
        r.sx = word_t'(pos_x[1]);
        r.sy = word_t'(pos_y[1]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random values
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    function automatic word_t scaled_word(int lo, int hi);
        return word_t'($urandom) >>> $urandom_range(lo, hi);
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2: return word_t'($urandom);
            3, 4, 5: return scaled_word(8, 28);
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default: return scaled_word(12, 20);
        endcase
    endfunction

    function automatic logic [tbss_pkg::CFG_W-1:0] pick_reg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return tbss_pkg::CFG_W'($urandom);
            default: return tbss_pkg::CFG_W'($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_item(logic op, logic sel, word_t px, word_t py,
                                     word_t vx, word_t vy);
        body_item_t it;
        it.op  = op;
        it.sel = sel;
        it.px  = px;
        it.py  = py;
        it.vx  = vx;
        it.vy  = vy;
        pending_items.push_back(it);
    endfunction

    // tick with junk in the fields it ignores
    function automatic void add_tick();
        add_item(tbss_pkg::OP_TICK, 1'($urandom), pick_word(), pick_word(), pick_word(),
                 pick_word());
    endfunction

    task automatic write_reg(input logic [tbss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbss_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            tbss_pkg::CFG_REST_LENGTH: rest_len = longint'(val);
            tbss_pkg::CFG_SPRING_K:    stiff    = longint'(val);
            tbss_pkg::CFG_MASS_FIRST:  mass_a   = longint'(val);
            tbss_pkg::CFG_MASS_SECOND: mass_b   = longint'(val);
            tbss_pkg::CFG_TIME_STEP:   dt       = longint'(val);
            default:                   ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [tbss_pkg::CFG_W-1:0] rest, k, m1, m2, step);
        write_reg(tbss_pkg::CFG_REST_LENGTH, rest);
        write_reg(tbss_pkg::CFG_SPRING_K, k);
        write_reg(tbss_pkg::CFG_MASS_FIRST, m1);
        write_reg(tbss_pkg::CFG_MASS_SECOND, m2);
        write_reg(tbss_pkg::CFG_TIME_STEP, step);
    endtask

    // sender holds off until everything sent has come back
    task automatic wait_idle();
        @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_pos.size() != 0)
            @(posedge clk);
    endtask

    // mostly load-both-bodies then a run of ticks, plus noise
    task automatic fill_random(int count);
        int n;
        int run;
        n = 0;
        while (n < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    add_item(1'($urandom), 1'($urandom), pick_word(), pick_word(),
                             pick_word(), pick_word());
                    n++;
                end
                1:
                begin
                    add_item(tbss_pkg::OP_LOAD, 1'($urandom), pick_word(), pick_word(),
                             pick_word(), pick_word());
                    n++;
                end
                default:
                begin
                    add_item(tbss_pkg::OP_LOAD, 1'b0, scaled_word(6, 14),
                             scaled_word(6, 14), scaled_word(10, 20),
                             scaled_word(10, 20));
                    add_item(tbss_pkg::OP_LOAD, 1'b1, scaled_word(6, 14),
                             scaled_word(6, 14), scaled_word(10, 20),
                             scaled_word(10, 20));
                    run = $urandom_range(2, 12);
                    repeat (run) add_tick();
                    n += run + 2;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: one item in flight on the channel at a time
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic next_valid;
        next_valid = in_valid;
        if (in_valid && in_took)
            next_valid = 1'b0;
        if (!next_valid && rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                operation   <= cur_item.op;
                body_select <= cur_item.sel;
                load_pos_x  <= cur_item.px;
                load_pos_y  <= cur_item.py;
                load_vel_x  <= cur_item.vx;
                load_vel_y  <= cur_item.vy;
                next_valid  = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    calm = !calm;
                send_gap = pick_gap();
            end
        end
        in_valid <= next_valid;
    end

    // output stall: drawn per transfer, counted down while a result waits
    always @(negedge clk)
    begin
        if (out_took)
            recv_gap = pick_gap();
        else if (out_valid && recv_gap > 0)
            recv_gap--;
        out_ready <= (recv_gap == 0);
    end

    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, name, want, want, got, got);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: check outputs first, then step the model on an input
    // transfer (a result never comes back in the cycle its item goes in)
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        body_item_t seen;
        body_pos_t  want;
        in_took  = 1'b0;
        out_took = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                out_took = 1'b1;
                if (expected_pos.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, actual %0d %0d %0d %0d",
                             $time, first_x, first_y, second_x, second_y);
                end
                else
                begin
                    want = expected_pos.pop_front();
                    check_field("first_x", want.fx, first_x);
                    check_field("first_y", want.fy, first_y);
                    check_field("second_x", want.sx, second_x);
                    check_field("second_y", want.sy, second_y);
                end
            end
            if (in_valid && in_ready)
            begin
                in_took  = 1'b1;
                seen.op  = operation;
                seen.sel = body_select;
                seen.px  = load_pos_x;
                seen.py  = load_pos_y;
                seen.vx  = load_vel_x;
                seen.vy  = load_vel_y;
                expected_pos.push_back(step_bodies(seen));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out, %0d results outstanding", $time,
                     expected_pos.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, on reset register values
        // tick with both bodies at the origin: zero length, no force
        add_tick();
        // opposite corners at full scale: saturated distance and velocity
        add_item(tbss_pkg::OP_LOAD, 1'b0, W_MAX, W_MIN, W_MAX, W_MIN);
        add_item(tbss_pkg::OP_LOAD, 1'b1, W_MIN, W_MAX, W_MIN, W_MAX);
        add_tick();
        add_tick();
        // stretched spring along x, bodies at rest
        add_item(tbss_pkg::OP_LOAD, 1'b0, '0, '0, '0, '0);
        add_item(tbss_pkg::OP_LOAD, 1'b1, 32'sd9830400, '0, '0, '0);
        repeat (3) add_tick();
        // compressed spring, 3-4-5 triangle
        add_item(tbss_pkg::OP_LOAD, 1'b1, 32'sd1966080, 32'sd2621440, '0, '0);
        repeat (2) add_tick();
        // second body back at the origin and moving
        add_item(tbss_pkg::OP_LOAD, 1'b1, '0, '0, 32'sd65536, -32'sd65536);
        repeat (2) add_tick();
        // ticks ignore select and load fields
        add_item(tbss_pkg::OP_TICK, 1'b1, -1, -1, -1, -1);
        add_item(tbss_pkg::OP_TICK, 1'b0, W_MIN, W_MAX, W_MIN, W_MAX);
        // small values and a load leaves the other body alone
        add_item(tbss_pkg::OP_LOAD, 1'b0, 1, -1, -1, 1);
        add_item(tbss_pkg::OP_LOAD, 1'b1, -1, 1, 1, -1);
        add_tick();
        wait_idle();

        // defaults
        fill_random(PHASE_ITEMS);
        wait_idle();

        // stiff, light and fast
        set_regs(31'd655360, 31'd65536, 31'd65536, 31'd65536, 31'd4096);
        fill_random(PHASE_ITEMS);
        wait_idle();

        // every register at its top value
        set_regs('1, '1, '1, '1, '1);
        fill_random(PHASE_ITEMS);
        wait_idle();

        // zero rest length and zero masses, full time step
        set_regs('0, 31'd65536, '0, '0, '1);
        fill_random(PHASE_ITEMS);
        wait_idle();

        // no stiffness, no time step, longest rest length
        set_regs('1, '0, 31'd1, 31'd1, '0);
        fill_random(PHASE_ITEMS);
        wait_idle();

        // random settings, plus writes to unmapped indexes
        set_regs(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
        write_reg(CFG_UNUSED_LO, pick_reg());
        write_reg(CFG_UNUSED_HI, pick_reg());
        write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), pick_reg());
        fill_random(PHASE_ITEMS);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
